### design/qmsm_pkg.sv
// Shared types and constants for the quality mode state machine.
// Used by every module in the design folder; depends on nothing.
package qmsm_pkg;

  // Default width of the run-length counters.
  localparam int unsigned RunCountWidthDef = 8;

  // Width of one threshold register and of the configuration data.
  localparam int unsigned ThrWidth = 8;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxWidth = 2;

  // Frame grades.
  typedef enum logic [1:0] {
    QUAL_GOOD     = 2'd0,
    QUAL_DEGRADED = 2'd1,
    QUAL_POOR     = 2'd2,
    QUAL_UNUSABLE = 2'd3
  } quality_e;

  // Operating modes.
  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_DEGRADED = 2'd1,
    MODE_FALLBACK = 2'd2,
    MODE_LOST     = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEGRADED_ENTER = 2'd0,
    CFG_POOR_ENTER     = 2'd1,
    CFG_UNUSABLE_ENTER = 2'd2,
    CFG_RECOVERY       = 2'd3
  } cfg_idx_e;

  // Threshold set handed from the register file to the mode logic.
  typedef struct packed {
    logic [ThrWidth-1:0] degraded_enter;
    logic [ThrWidth-1:0] poor_enter;
    logic [ThrWidth-1:0] unusable_enter;
    logic [ThrWidth-1:0] recovery;
  } qmsm_cfg_t;

  // Reset values of the thresholds.
  localparam logic [ThrWidth-1:0] DegradedEnterRst = 8'd3;
  localparam logic [ThrWidth-1:0] PoorEnterRst     = 8'd5;
  localparam logic [ThrWidth-1:0] UnusableEnterRst = 8'd10;
  localparam logic [ThrWidth-1:0] RecoveryRst      = 8'd5;

endpackage

### design/quality_mode_state_machine_unit.sv
// Quality mode state machine: input register, mode logic and result register.
// Depends on qmsm_pkg, qmsm_cfg_regs and qmsm_mode_core.
//
// Usage:
//   Input channel: in_valid_i, in_stall_o and quality_i carry one frame grade
//   per item. Output channel: out_valid_o, out_stall_i, mode_o and
//   mode_changed_o carry one result item per input item, in order.
//   An item moves on an edge where valid is high and stall is low.
//   Configuration: cfg_we_i writes cfg_wdata_i into threshold cfg_idx_i
//   (0 degraded enter, 1 poor enter, 2 unusable enter, 3 recovery); write
//   only while the block is idle.
//   Pipeline: an accepted item is held in the input register; the mode logic
//   computes its result, which is loaded into the result register and taken
//   from there by the receiver.
//   Throughput: one item per cycle while the receiver does not stall; the mode
//   logic between the two registers computes the new counters and mode combinationally.
//   Stall: while the receiver stalls a held result, the result register
//   holds and one more item is still taken into the input register if it is
//   empty; after that in_stall_o rises until the result is taken.
//   Reset: mode returns to normal, all run counters clear, thresholds take
//   their defaults (3, 5, 10, 5) and both registers empty.
module quality_mode_state_machine_unit #(
  parameter int unsigned RunCountWidth = qmsm_pkg::RunCountWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       quality_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       mode_o,
  output logic                             mode_changed_o,
  input  logic                             cfg_we_i,
  input  logic [qmsm_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [qmsm_pkg::ThrWidth-1:0]    cfg_wdata_i
);
  import qmsm_pkg::*;

  qmsm_cfg_t  cfg;
  logic       in_vld_q;
  logic [1:0] in_qual_q;
  logic       out_vld_q;
  logic [1:0] out_mode_q;
  logic       out_chg_q;
  logic       advance;
  logic       step;
  logic [1:0] mode_nxt;
  logic       chg_nxt;

  // The result register can load when empty or being taken this cycle.
  assign advance    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  qmsm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  qmsm_mode_core #(
    .RunCountWidth (RunCountWidth)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .quality_i      (in_qual_q),
    .cfg_i          (cfg),
    .mode_o         (mode_nxt),
    .mode_changed_o (chg_nxt)
  );

  // Input register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_qual_q <= quality_i;
    end
  end

  // Result register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_mode_q <= mode_nxt;
      out_chg_q  <= chg_nxt;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign mode_o         = out_mode_q;
  assign mode_changed_o = out_chg_q;

endmodule

### design/qmsm_cfg_regs.sv
// Threshold register file of the quality mode state machine.
// Depends on qmsm_pkg for the register indexes and the threshold struct.
module qmsm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qmsm_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [qmsm_pkg::ThrWidth-1:0]    cfg_wdata_i,
  output qmsm_pkg::qmsm_cfg_t              cfg_o
);
  import qmsm_pkg::*;

  qmsm_cfg_t cfg_q, cfg_d;

  // Decode the write index and update the addressed threshold.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEGRADED_ENTER: cfg_d.degraded_enter = cfg_wdata_i;
        CFG_POOR_ENTER:     cfg_d.poor_enter     = cfg_wdata_i;
        CFG_UNUSABLE_ENTER: cfg_d.unusable_enter = cfg_wdata_i;
        CFG_RECOVERY:       cfg_d.recovery       = cfg_wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  // Threshold registers, reset to their documented defaults.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.degraded_enter <= DegradedEnterRst;
      cfg_q.poor_enter     <= PoorEnterRst;
      cfg_q.unusable_enter <= UnusableEnterRst;
      cfg_q.recovery       <= RecoveryRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/qmsm_mode_core.sv
// Run-length counters and mode state machine of the quality mode block.
// Depends on qmsm_pkg for the grade and mode enums and the threshold struct.
module qmsm_mode_core #(
  parameter int unsigned RunCountWidth = qmsm_pkg::RunCountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          quality_i,
  input  qmsm_pkg::qmsm_cfg_t cfg_i,
  output logic [1:0]          mode_o,
  output logic                mode_changed_o
);
  import qmsm_pkg::*;

  // Compare width covers both the counters and the thresholds.
  localparam int unsigned CmpWidth = (RunCountWidth > ThrWidth) ? RunCountWidth : ThrWidth;

  mode_e mode_q, mode_d;
  logic [RunCountWidth-1:0] good_q, degr_q, poor_q, unus_q;
  logic [RunCountWidth-1:0] good_d, degr_d, poor_d, unus_d;

  // Saturating increment of a run counter.
  function automatic logic [RunCountWidth-1:0] bump(input logic [RunCountWidth-1:0] v);
    bump = (v == {RunCountWidth{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Unsigned counter >= threshold, both zero-extended to a common width.
  function automatic logic reached(input logic [RunCountWidth-1:0] run,
                                   input logic [ThrWidth-1:0] thr);
    reached = CmpWidth'(run) >= CmpWidth'(thr);
  endfunction

  // Counter update: the current grade's run grows, the others clear.
  always_comb begin
    good_d = '0;
    degr_d = '0;
    poor_d = '0;
    unus_d = '0;
    case (quality_e'(quality_i))
      QUAL_GOOD:     good_d = bump(good_q);
      QUAL_DEGRADED: degr_d = bump(degr_q);
      QUAL_POOR:     poor_d = bump(poor_q);
      default:       unus_d = bump(unus_q);
    endcase
  end

  // Prioritized transition rules on the updated counters.
  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      MODE_NORMAL: begin
        if (reached(unus_d, cfg_i.unusable_enter))      mode_d = MODE_LOST;
        else if (reached(poor_d, cfg_i.poor_enter))     mode_d = MODE_FALLBACK;
        else if (reached(degr_d, cfg_i.degraded_enter)) mode_d = MODE_DEGRADED;
      end
      MODE_DEGRADED: begin
        if (reached(unus_d, cfg_i.unusable_enter))  mode_d = MODE_LOST;
        else if (reached(poor_d, cfg_i.poor_enter)) mode_d = MODE_FALLBACK;
        else if (reached(good_d, cfg_i.recovery))   mode_d = MODE_NORMAL;
      end
      MODE_FALLBACK: begin
        if (reached(unus_d, cfg_i.unusable_enter)) mode_d = MODE_LOST;
        else if (reached(good_d, cfg_i.recovery))  mode_d = MODE_NORMAL;
        else if (reached(degr_d, cfg_i.recovery))  mode_d = MODE_DEGRADED;
      end
      default: begin
        if (reached(good_d, cfg_i.recovery))      mode_d = MODE_NORMAL;
        else if (reached(degr_d, cfg_i.recovery)) mode_d = MODE_DEGRADED;
        else if (reached(poor_d, cfg_i.recovery)) mode_d = MODE_FALLBACK;
      end
    endcase
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      good_q <= '0;
      degr_q <= '0;
      poor_q <= '0;
      unus_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      good_q <= good_d;
      degr_q <= degr_d;
      poor_q <= poor_d;
      unus_q <= unus_d;
    end
  end

  assign mode_o         = mode_d;
  assign mode_changed_o = (mode_d != mode_q);

endmodule
